/* sv/crl_pkg.sv */
// Shared constants, types and tables of the calibrated range linearizer.
`timescale 1ns / 1ps
package crl_pkg;

  localparam int ADC_BITS_DEF       = 12;
  localparam int DIST_FRAC_BITS_DEF = 8;
  localparam int NUM_POINTS         = 5;
  localparam int INV_BITS           = 14;  // Q0.16 inverse distances stay below 2^14
  localparam int DX_BITS            = 13;  // largest step between table entries
  localparam int DIST_BITS          = 15;
  localparam int STATUS_BITS        = 2;
  localparam int CFG_IDX_BITS       = 3;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_INTERP = 2'd0,
    ST_FAR    = 2'd1,
    ST_NEAR   = 2'd2,
    ST_FAULT  = 2'd3
  } range_status_t;

  // Inverse distance of each calibration point, Q0.16.
  function automatic logic [INV_BITS-1:0] inv_point(input logic [2:0] idx);
    logic [INV_BITS-1:0] v;
    case (idx)
      3'd0:    v = 14'd819;
      3'd1:    v = 14'd1638;
      3'd2:    v = 14'd6554;
      3'd3:    v = 14'd9362;
      3'd4:    v = 14'd13107;
      default: v = 14'd819;
    endcase
    return v;
  endfunction

endpackage

/* sv/crl_div_cell.sv */
// One restoring-division cell: develops one quotient bit per stage.
`timescale 1ns / 1ps
module crl_div_cell #(
  parameter int NUM_BITS = 24,
  parameter int DEN_BITS = 12,
  parameter int REM_BITS = 13,
  parameter int SIDE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic [NUM_BITS-1:0]  num_i,   // numerator; quotient bits shift in at the bottom
  input  logic [REM_BITS-1:0]  rem_i,
  input  logic [DEN_BITS-1:0]  den_i,
  input  logic [SIDE_BITS-1:0] side_i,
  output logic                 valid_o,
  output logic [NUM_BITS-1:0]  num_o,
  output logic [REM_BITS-1:0]  rem_o,
  output logic [DEN_BITS-1:0]  den_o,
  output logic [SIDE_BITS-1:0] side_o
);

  logic                 valid_r;
  logic [NUM_BITS-1:0]  num_r, num_nxt;
  logic [REM_BITS-1:0]  rem_r, rem_nxt;
  logic [DEN_BITS-1:0]  den_r;
  logic [SIDE_BITS-1:0] side_r;
  logic [REM_BITS:0]    trial;
  logic [REM_BITS:0]    diff;

  always_comb begin
    trial = {rem_i, num_i[NUM_BITS-1]};
    diff  = trial - {{(REM_BITS+1-DEN_BITS){1'b0}}, den_i};
    if (!diff[REM_BITS]) begin
      rem_nxt = diff[REM_BITS-1:0];
      num_nxt = {num_i[NUM_BITS-2:0], 1'b1};
    end else begin
      rem_nxt = trial[REM_BITS-1:0];
      num_nxt = {num_i[NUM_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
    if (en) begin
      num_r  <= num_nxt;
      rem_r  <= rem_nxt;
      den_r  <= den_i;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign num_o   = num_r;
  assign rem_o   = rem_r;
  assign den_o   = den_r;
  assign side_o  = side_r;

endmodule

/* sv/crl_div_chain.sv */
// Row of division cells: unsigned quotient, one bit per cell, one item per cycle while en is high.
`timescale 1ns / 1ps
module crl_div_chain #(
  parameter int NUM_BITS = 24,
  parameter int DEN_BITS = 12,
  parameter int SIDE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  logic [NUM_BITS-1:0]  num_i,
  input  logic [DEN_BITS-1:0]  den_i,
  input  logic [SIDE_BITS-1:0] side_i,
  output logic                 valid_o,
  output logic [NUM_BITS-1:0]  quot_o,
  output logic [DEN_BITS-1:0]  rem_o,
  output logic [SIDE_BITS-1:0] side_o
);

  localparam int REM_BITS = DEN_BITS + 1;

  logic                 v   [NUM_BITS+1];
  logic [NUM_BITS-1:0]  n   [NUM_BITS+1];
  logic [REM_BITS-1:0]  r   [NUM_BITS+1];
  logic [DEN_BITS-1:0]  d   [NUM_BITS+1];
  logic [SIDE_BITS-1:0] s   [NUM_BITS+1];

  assign v[0] = valid_i;
  assign n[0] = num_i;
  assign r[0] = '0;
  assign d[0] = den_i;
  assign s[0] = side_i;

  for (genvar g = 0; g < NUM_BITS; g++) begin : g_cell
    crl_div_cell #(
      .NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS),
      .REM_BITS(REM_BITS), .SIDE_BITS(SIDE_BITS)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(v[g]), .num_i(n[g]), .rem_i(r[g]), .den_i(d[g]), .side_i(s[g]),
      .valid_o(v[g+1]), .num_o(n[g+1]), .rem_o(r[g+1]), .den_o(d[g+1]),
      .side_o(s[g+1])
    );
  end

  assign valid_o = v[NUM_BITS];
  assign quot_o  = n[NUM_BITS];
  assign rem_o   = r[NUM_BITS][DEN_BITS-1:0];
  assign side_o  = s[NUM_BITS];

endmodule

/* sv/calibrated_range_linearizer.sv */
// Calibrated range linearizer: converter code to distance, 1/2^DIST_FRAC_BITS cm.
// Pipeline: four pipeline registers and two rows of division cells, one quotient bit per
// cell: ADC_BITS + DX_BITS cells in the first row, 17 + INV_BITS + DIST_FRAC_BITS in the
// second.
// Throughput: one beat per cycle unless the output stalls; each row takes a new item every such cycle.
// Reset (rst_n low, synchronous) empties the pipeline and loads the calibration defaults.
`timescale 1ns / 1ps
module calibrated_range_linearizer #(
  parameter int ADC_BITS       = crl_pkg::ADC_BITS_DEF,
  parameter int DIST_FRAC_BITS = crl_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((ADC_BITS+7)/8)*8-1:0]       in_tdata,   // [ADC_BITS-1:0] adc_code
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [23:0]                         out_tdata,  // [14:0] distance_q8, [16:15] range_status
  input  logic                                cfg_we,
  input  logic [crl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ADC_BITS-1:0]                 cfg_data
);

  localparam int INV_BITS  = crl_pkg::INV_BITS;
  localparam int DX_BITS   = crl_pkg::DX_BITS;
  localparam int DIST_BITS = crl_pkg::DIST_BITS;
  localparam int ST_BITS   = crl_pkg::STATUS_BITS;
  localparam int PROD_BITS = ADC_BITS + DX_BITS;
  localparam int RNUM_BITS = 17 + DIST_FRAC_BITS + INV_BITS; // holds 2^(16+F)*2 + inv
  localparam int S1_SIDE   = INV_BITS + ST_BITS;
  localparam int S2_SIDE   = ST_BITS;
  localparam int DEN2_BITS = INV_BITS + 1;
  localparam int DIST_W    = DIST_FRAC_BITS + 7;  // 80 cm fits
  localparam logic [DIST_W-1:0] D_LO = DIST_W'(5) << DIST_FRAC_BITS;
  localparam logic [DIST_W-1:0] D_HI = DIST_W'(80) << DIST_FRAC_BITS;

  // Calibration registers.
  logic [ADC_BITS-1:0] cal_r [crl_pkg::NUM_POINTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r[0] <= ADC_BITS'(400);
      cal_r[1] <= ADC_BITS'(800);
      cal_r[2] <= ADC_BITS'(2300);
      cal_r[3] <= ADC_BITS'(2900);
      cal_r[4] <= ADC_BITS'(3500);
    end else if (cfg_we && (cfg_index < 3'(crl_pkg::NUM_POINTS))) begin
      cal_r[cfg_index] <= cfg_data;
    end
  end

  // Stall the whole pipeline while the output holds an untaken beat.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Stage A: segment select, range status, offset, step sizes, base inverse distance.
  logic [ADC_BITS-1:0] code;
  logic [2:0]          seg;
  logic                seg_ok;
  logic [1:0]          st_a;
  assign code = in_tdata[ADC_BITS-1:0];

  always_comb begin
    seg    = 3'd0;
    seg_ok = 1'b0;
    for (int i = crl_pkg::NUM_POINTS - 2; i >= 0; i--) begin
      if (!seg_ok && code >= cal_r[i] && code < cal_r[i+1]) begin
        seg    = 3'(i);
        seg_ok = 1'b1;
      end
    end
    if (code <= cal_r[0])                          st_a = crl_pkg::ST_FAR;
    else if (code >= cal_r[crl_pkg::NUM_POINTS-1]) st_a = crl_pkg::ST_NEAR;
    else if (seg_ok)                               st_a = crl_pkg::ST_INTERP;
    else                                           st_a = crl_pkg::ST_FAULT;
  end

  logic                va_r;
  logic [ADC_BITS-1:0] off_r, dp_r;
  logic [DX_BITS-1:0]  dx_r;
  logic [INV_BITS-1:0] x0_r;
  logic [1:0]          sta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (adv) va_r <= in_tvalid;
    if (adv) begin
      off_r <= code - cal_r[seg];
      dp_r  <= (st_a == crl_pkg::ST_INTERP) ? cal_r[seg+3'd1] - cal_r[seg] : ADC_BITS'(1);
      dx_r  <= DX_BITS'(crl_pkg::inv_point(seg + 3'd1) - crl_pkg::inv_point(seg));
      x0_r  <= crl_pkg::inv_point(seg);
      sta_r <= st_a;
    end
  end

  // Stage B: product.
  logic                 vb_r;
  logic [PROD_BITS-1:0] prod_r;
  logic [ADC_BITS-1:0]  dpb_r;
  logic [S1_SIDE-1:0]   sideb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (adv) vb_r <= va_r;
    if (adv) begin
      prod_r  <= PROD_BITS'(off_r) * PROD_BITS'(dx_r);
      dpb_r   <= dp_r;
      sideb_r <= {x0_r, sta_r};
    end
  end

  // First row of cells: product / segment width.
  logic                 v1;
  logic [PROD_BITS-1:0] q1;
  logic [ADC_BITS-1:0]  r1;
  logic [S1_SIDE-1:0]   s1;

  crl_div_chain #(.NUM_BITS(PROD_BITS), .DEN_BITS(ADC_BITS), .SIDE_BITS(S1_SIDE))
    u_div1 (.clk(clk), .rst_n(rst_n), .en(adv), .valid_i(vb_r), .num_i(prod_r),
            .den_i(dpb_r), .side_i(sideb_r), .valid_o(v1), .quot_o(q1), .rem_o(r1),
            .side_o(s1));

  // Stage C: inverse distance and rounded reciprocal numerator.
  logic                 vc_r;
  logic [RNUM_BITS-1:0] rnum_r;
  logic [DEN2_BITS-1:0] inv_r;
  logic [1:0]           stc_r;
  logic [DEN2_BITS-1:0] inv_c;

  assign inv_c = DEN2_BITS'(s1[S1_SIDE-1:ST_BITS]) + DEN2_BITS'(q1);

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (adv) vc_r <= v1;
    if (adv) begin
      rnum_r <= (RNUM_BITS'(1) << (16 + DIST_FRAC_BITS)) + RNUM_BITS'(inv_c >> 1);
      inv_r  <= (s1[ST_BITS-1:0] == crl_pkg::ST_INTERP) ? inv_c : DEN2_BITS'(1);
      stc_r  <= s1[ST_BITS-1:0];
    end
  end

  // Second row of cells: reciprocal.
  logic                 v2;
  logic [RNUM_BITS-1:0] q2;
  logic [DEN2_BITS-1:0] r2;
  logic [S2_SIDE-1:0]   s2;

  crl_div_chain #(.NUM_BITS(RNUM_BITS), .DEN_BITS(DEN2_BITS), .SIDE_BITS(S2_SIDE))
    u_div2 (.clk(clk), .rst_n(rst_n), .en(adv), .valid_i(vc_r), .num_i(rnum_r),
            .den_i(inv_r), .side_i(stc_r), .valid_o(v2), .quot_o(q2), .rem_o(r2),
            .side_o(s2));

  // Output stage: clamp and status.
  logic [DIST_W-1:0] dist_c;
  logic [DIST_BITS-1:0] dist_r;
  logic [1:0] sto_r;
  logic       vo_r;

  always_comb begin
    case (s2)
      crl_pkg::ST_FAR:  dist_c = D_HI;
      crl_pkg::ST_NEAR: dist_c = D_LO;
      crl_pkg::ST_INTERP: begin
        if (q2 < RNUM_BITS'(D_LO))      dist_c = D_LO;
        else if (q2 > RNUM_BITS'(D_HI)) dist_c = D_HI;
        else                            dist_c = q2[DIST_W-1:0];
      end
      default: dist_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (adv) vo_r <= v2;
    if (adv) begin
      dist_r <= DIST_BITS'(dist_c);
      sto_r  <= s2;
    end
  end

  logic unused_rem;
  assign unused_rem = ^{r1, r2};

  assign out_tvalid = vo_r;
  assign out_tdata  = {7'd0, sto_r, dist_r} | {23'd0, unused_rem & 1'b0};

endmodule

/* tb/tb_calibrated_range_linearizer.sv */
// Self-checking testbench of the calibrated range linearizer.
`timescale 1ns / 1ps
module tb_calibrated_range_linearizer;

  localparam int LATENCY = 4 + 12 + crl_pkg::DX_BITS + 17 + crl_pkg::INV_BITS + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CAL_REGS = 5;

  // Packed from the top bit down, so the distance sits in the low bits as on out_tdata.
  typedef struct packed {
    crl_pkg::range_status_t status;
    logic [14:0]            distance;
  } range_result_t;

  typedef struct {
    logic [11:0]   code;
    bit            typed;
    range_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [crl_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;

  logic [11:0]   cal_points[CAL_REGS];
  range_result_t pending_ranges[$];
  int unsigned   cycle_count = 0;
  int unsigned   error_count = 0;
  int unsigned   beats_checked = 0;
  int unsigned   status_seen[4] = '{0, 0, 0, 0};
  bit            stall_enable = 1'b1;
  stim_row_t     directed_rows[$];

  calibrated_range_linearizer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [13:0] inv_of_point(int idx);
    case (idx)
      0: return 14'd819;
      1: return 14'd1638;
      2: return 14'd6554;
      3: return 14'd9362;
      default: return 14'd13107;
    endcase
  endfunction

  function automatic range_result_t linearize(logic [11:0] code);
    range_result_t r;
    longint unsigned inv, d, dp, dx, off;
    int seg;
    r.distance = '0;
    r.status = crl_pkg::ST_FAULT;
    seg = -1;
    if (code <= cal_points[0]) begin
      r.distance = 15'(80 << 8);
      r.status = crl_pkg::ST_FAR;
    end else if (code >= cal_points[4]) begin
      r.distance = 15'(5 << 8);
      r.status = crl_pkg::ST_NEAR;
    end else begin
      for (int i = 3; i >= 0; i--) begin
        if (seg < 0 && code >= cal_points[i] && code < cal_points[i+1]) seg = i;
      end
      if (seg >= 0) begin
        dp = 64'(cal_points[seg+1]) - 64'(cal_points[seg]);
        dx = 64'(inv_of_point(seg+1)) - 64'(inv_of_point(seg));
        off = 64'(code) - 64'(cal_points[seg]);
        inv = 64'(inv_of_point(seg)) + (off * dx) / dp;
        d = ((64'd1 << 24) + inv / 2) / inv;
        if (d < 64'(5 << 8)) d = 64'(5 << 8);
        if (d > 64'(80 << 8)) d = 64'(80 << 8);
        r.distance = 15'(d);
        r.status = crl_pkg::ST_INTERP;
      end
    end
    return r;
  endfunction

  // Drops the valid only when an idle gap actually follows.
  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    if (!stall_enable || $urandom_range(0, 2) == 0) n = 0;
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sends one beat; the expectation is queued at the accepting edge.
  task automatic send_code(logic [11:0] code, bit typed, range_result_t res);
    random_gap();
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, code};
    do @(posedge clk); while (!in_tready);
    pending_ranges.push_back(typed ? res : linearize(code));
  endtask

  task automatic write_cal(int idx, logic [11:0] value);
    cfg_we <= 1'b1;
    cfg_index <= crl_pkg::CFG_IDX_BITS'(idx);
    cfg_data <= value;
    @(posedge clk);
    cal_points[idx] = value;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic load_cal(logic [11:0] p0, p1, p2, p3, p4);
    drain();
    write_cal(0, p0); write_cal(1, p1); write_cal(2, p2);
    write_cal(3, p3); write_cal(4, p4);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(logic [11:0] code, bit typed, logic [14:0] distance,
                         crl_pkg::range_status_t st);
    stim_row_t row;
    row.code = code;
    row.typed = typed;
    row.res.distance = distance;
    row.res.status = st;
    directed_rows.push_back(row);
  endtask

  // Output side: random backpressure and in-order compare.
  always @(posedge clk) begin
    range_result_t got, want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = range_result_t'(out_tdata[16:0]);
      if (pending_ranges.size() == 0) begin
        $error("unexpected result beat %h", out_tdata);
        error_count++;
      end else begin
        want = pending_ranges.pop_front();
        if (got.distance !== want.distance) begin
          $error("distance_q8 expected %0d actual %0d", want.distance, got.distance);
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("range_status expected %0d actual %0d", want.status, got.status);
          error_count++;
        end
        status_seen[want.status]++;
        beats_checked++;
      end
    end
    if (!stall_enable) out_tready <= 1'b1;
    else if ($urandom_range(0, 29) == 0) out_tready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_tready <= ~out_tready;
    else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int mode;
    logic [11:0] pts[CAL_REGS];
    logic [11:0] code;
    cal_points = '{12'd400, 12'd800, 12'd2300, 12'd2900, 12'd3500};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults after reset: clamps at both ends, the near point itself clamps; inner codes interpolate.
    add_row(12'd0, 1, 15'd20480, crl_pkg::ST_FAR);
    add_row(12'd400, 1, 15'd20480, crl_pkg::ST_FAR);
    add_row(12'd4095, 1, 15'd1280, crl_pkg::ST_NEAR);
    add_row(12'd3500, 1, 15'd1280, crl_pkg::ST_NEAR);
    add_row(12'd800, 0, '0, crl_pkg::ST_INTERP);
    add_row(12'd2300, 1, 15'd2560, crl_pkg::ST_INTERP);
    add_row(12'd401, 0, '0, crl_pkg::ST_INTERP);
    add_row(12'd2900, 0, '0, crl_pkg::ST_INTERP);
    add_row(12'd3499, 0, '0, crl_pkg::ST_INTERP);
    add_row(12'd1500, 0, '0, crl_pkg::ST_INTERP);
    add_row(12'd2600, 0, '0, crl_pkg::ST_INTERP);
    add_row(12'd2047, 0, '0, crl_pkg::ST_INTERP);
    foreach (directed_rows[i])
      send_code(directed_rows[i].code, directed_rows[i].typed, directed_rows[i].res);

    // Out-of-order calibration: a reversed segment never holds a code.
    load_cal(12'd100, 12'd2000, 12'd1500, 12'd3000, 12'd4000);
    send_code(12'd1800, 0, '0);
    send_code(12'd1999, 0, '0);
    send_code(12'd1000, 0, '0);
    send_code(12'd3500, 0, '0);
    // Extreme settings.
    load_cal(12'd0, 12'd1, 12'd2, 12'd3, 12'd4095);
    send_code(12'd4094, 0, '0);
    send_code(12'd3, 0, '0);
    load_cal(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    send_code(12'd4095, 1, '{distance: 15'd20480, status: crl_pkg::ST_FAR});
    send_code(12'd0, 1, '{distance: 15'd20480, status: crl_pkg::ST_FAR});

    for (int blk = 0; blk < 21; blk++) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        // Ordered points with random spacing.
        pts[0] = 12'($urandom_range(0, 800));
        for (int k = 1; k < CAL_REGS; k++)
          pts[k] = pts[k-1] + 12'($urandom_range(1, (4095 - pts[k-1]) / (CAL_REGS - k)));
      end else begin
        for (int k = 0; k < CAL_REGS; k++) pts[k] = 12'($urandom_range(0, 4095));
      end
      load_cal(pts[0], pts[1], pts[2], pts[3], pts[4]);
      stall_enable = (blk % 4 != 3);
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 4) == 0) code = 12'($urandom_range(0, 4095));
        else begin
          code = cal_points[$urandom_range(0, 4)];
          code = code + 12'($urandom_range(0, 4)) - 12'd2;
          if ($urandom_range(0, 1)) code = 12'($urandom_range(cal_points[0], 4095));
        end
        send_code(code, 0, '0);
      end
    end
    stall_enable = 1'b1;
    drain();
    $display("checked %0d result beats over 25 calibration settings", beats_checked);
    $display("status counts: interp %0d far %0d near %0d fault %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0 && pending_ranges.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
sv/crl_pkg.sv
sv/crl_div_cell.sv
sv/crl_div_chain.sv
sv/calibrated_range_linearizer.sv
tb/tb_calibrated_range_linearizer.sv
